// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the tokenizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/mlt_pkg.sv -----
// ----------------------------------------------------------------------------
// Mini language tokenizer package
// Token kinds, scanner modes, token record and keyword matching.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlt_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam int unsigned PosW  = 24;
  localparam int unsigned LenW  = 16;
  localparam int unsigned LineW = 16;

  localparam logic [PosW-1:0]  PosMax  = '1;
  localparam logic [LenW-1:0]  LenMax  = '1;
  localparam logic [LineW-1:0] LineMax = '1;

  localparam logic [7:0] ChrEnd       = 8'h00;
  localparam logic [7:0] ChrTab       = 8'h09;
  localparam logic [7:0] ChrNewline   = 8'h0A;
  localparam logic [7:0] ChrSpace     = 8'h20;
  localparam logic [7:0] ChrUnderscore = 8'h5F;
  localparam logic [7:0] ChrPlus      = 8'h2B;
  localparam logic [7:0] ChrMinus     = 8'h2D;
  localparam logic [7:0] ChrStar      = 8'h2A;
  localparam logic [7:0] ChrSlash     = 8'h2F;
  localparam logic [7:0] ChrEqual     = 8'h3D;
  localparam logic [7:0] ChrSemi      = 8'h3B;
  localparam logic [7:0] ChrLparen    = 8'h28;
  localparam logic [7:0] ChrRparen    = 8'h29;
  localparam logic [7:0] ChrLowP      = 8'h70;
  localparam logic [7:0] ChrLowR      = 8'h72;
  localparam logic [7:0] ChrLowI      = 8'h69;
  localparam logic [7:0] ChrLowN      = 8'h6E;
  localparam logic [7:0] ChrLowT      = 8'h74;

  // Keyword progress: prefixes of "print" and of "int".
  localparam logic [3:0] KwNone = 4'd0;
  localparam logic [3:0] KwP    = 4'd1;
  localparam logic [3:0] KwPr   = 4'd2;
  localparam logic [3:0] KwPri  = 4'd3;
  localparam logic [3:0] KwPrin = 4'd4;
  localparam logic [3:0] KwPrint = 4'd5;
  localparam logic [3:0] KwI    = 4'd6;
  localparam logic [3:0] KwIn   = 4'd7;
  localparam logic [3:0] KwInt  = 4'd8;

  typedef enum logic [3:0] {
    TK_END    = 4'd0,
    TK_IDENT  = 4'd1,
    TK_NUMBER = 4'd2,
    TK_PRINT  = 4'd3,
    TK_INT    = 4'd4,
    TK_PLUS   = 4'd5,
    TK_MINUS  = 4'd6,
    TK_STAR   = 4'd7,
    TK_SLASH  = 4'd8,
    TK_EQUAL  = 4'd9,
    TK_SEMI   = 4'd10,
    TK_LPAREN = 4'd11,
    TK_RPAREN = 4'd12,
    TK_ERROR  = 4'd13
  } tok_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_e;

  typedef struct packed {
    logic             last;
    logic [LineW-1:0] line;
    logic [LenW-1:0]  length;
    logic [PosW-1:0]  start;
    tok_kind_e        kind;
  } token_t;

  function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
    logic [3:0] n;
    n = KwNone;
    if (p == KwP && c == ChrLowR) n = KwPr;
    if (p == KwPr && c == ChrLowI) n = KwPri;
    if (p == KwPri && c == ChrLowN) n = KwPrin;
    if (p == KwPrin && c == ChrLowT) n = KwPrint;
    if (p == KwI && c == ChrLowN) n = KwIn;
    if (p == KwIn && c == ChrLowT) n = KwInt;
    return n;
  endfunction

endpackage

// ----- rtl/core/mini_language_tokenizer_top.sv -----
// Throughput: one byte per cycle while the queue has room for two tokens; a byte that closes
// a token and forms its own gives two tokens, and the output side moves one token per cycle,
// while the receiver is ready, through a four-entry queue.
// Reset: rst_ni clears the scanner to line 1, offset 0, no open token, and empties the queue.
// The scanner returns to line 1, offset 0 and no open token by itself after each end token.
// ----------------------------------------------------------------------------
// Mini language tokenizer top level
// Byte-serial lexical scanner with a registered input byte and a token queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mini_language_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // token_kind[3:0], token_start[27:4],
                                        // token_length[43:28], token_line[59:44], zero
  output logic        m_axis_tlast_o    // last_of_run
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                proc_en;

  mlt_pkg::scan_mode_e             mode_q, mode_d;
  logic [3:0]                      kp_q, kp_d;
  logic [mlt_pkg::PosW-1:0]        origin_q, origin_d;
  logic [mlt_pkg::LenW-1:0]        len_q, len_d;
  logic [mlt_pkg::LineW-1:0]       line_q, line_d;
  logic [mlt_pkg::PosW-1:0]        pos_q, pos_d;

  logic                is_letter, is_digit, is_space, extend;
  logic                push_a, push_b;
  mlt_pkg::token_t     res_a, res_b;
  mlt_pkg::tok_kind_e  op_kind;

  mlt_pkg::token_t                 fifo_q [mlt_pkg::FifoDepth];
  logic [mlt_pkg::FifoAw-1:0]      wr_q, rd_q, idx_b;
  logic [mlt_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                            pop;
  mlt_pkg::token_t                 head;

  assign proc_en = in_valid_q && (cnt_q <= mlt_pkg::CntW'(mlt_pkg::FifoDepth - 2));
  assign s_axis_tready_o = !in_valid_q || proc_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_comb begin
    is_letter = in_byte_q inside {[8'h61:8'h7A], [8'h41:8'h5A], mlt_pkg::ChrUnderscore};
    is_digit  = in_byte_q inside {[8'h30:8'h39]};
    is_space  = in_byte_q inside {mlt_pkg::ChrSpace, mlt_pkg::ChrTab, mlt_pkg::ChrNewline};
    extend    = (mode_q == mlt_pkg::MODE_IDENT && (is_letter || is_digit)) ||
                (mode_q == mlt_pkg::MODE_NUMBER && is_digit);
  end

  always_comb begin
    case (in_byte_q)
      mlt_pkg::ChrPlus:   op_kind = mlt_pkg::TK_PLUS;
      mlt_pkg::ChrMinus:  op_kind = mlt_pkg::TK_MINUS;
      mlt_pkg::ChrStar:   op_kind = mlt_pkg::TK_STAR;
      mlt_pkg::ChrSlash:  op_kind = mlt_pkg::TK_SLASH;
      mlt_pkg::ChrEqual:  op_kind = mlt_pkg::TK_EQUAL;
      mlt_pkg::ChrSemi:   op_kind = mlt_pkg::TK_SEMI;
      mlt_pkg::ChrLparen: op_kind = mlt_pkg::TK_LPAREN;
      mlt_pkg::ChrRparen: op_kind = mlt_pkg::TK_RPAREN;
      default:            op_kind = mlt_pkg::TK_ERROR;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    kp_d     = kp_q;
    origin_d = origin_q;
    len_d    = len_q;
    line_d   = line_q;
    pos_d    = (pos_q != mlt_pkg::PosMax) ? pos_q + 1'b1 : pos_q;

    push_a = 1'b0;
    push_b = 1'b0;

    res_a.kind   = mlt_pkg::TK_IDENT;
    if (mode_q == mlt_pkg::MODE_NUMBER) begin
      res_a.kind = mlt_pkg::TK_NUMBER;
    end else if (kp_q == mlt_pkg::KwPrint) begin
      res_a.kind = mlt_pkg::TK_PRINT;
    end else if (kp_q == mlt_pkg::KwInt) begin
      res_a.kind = mlt_pkg::TK_INT;
    end
    res_a.start  = origin_q;
    res_a.length = len_q;
    res_a.line   = line_q;
    res_a.last   = 1'b1;

    res_b.kind   = op_kind;
    res_b.start  = pos_q;
    res_b.length = mlt_pkg::LenW'(1);
    res_b.line   = line_q;
    res_b.last   = 1'b1;

    if (extend) begin
      if (len_q != mlt_pkg::LenMax) len_d = len_q + 1'b1;
      if (mode_q == mlt_pkg::MODE_IDENT) kp_d = mlt_pkg::kw_next(kp_q, in_byte_q);
    end else begin
      push_a = (mode_q != mlt_pkg::MODE_IDLE);
      mode_d = mlt_pkg::MODE_IDLE;
      if (in_byte_q == mlt_pkg::ChrEnd) begin
        push_b       = 1'b1;
        res_b.kind   = mlt_pkg::TK_END;
        res_b.length = '0;
        mode_d       = mlt_pkg::MODE_IDLE;
        kp_d         = mlt_pkg::KwNone;
        origin_d     = '0;
        len_d        = '0;
        line_d       = mlt_pkg::LineW'(1);
        pos_d        = '0;
      end else if (is_space) begin
        if (in_byte_q == mlt_pkg::ChrNewline && line_q != mlt_pkg::LineMax) begin
          line_d = line_q + 1'b1;
        end
      end else if (is_letter || is_digit) begin
        mode_d   = is_letter ? mlt_pkg::MODE_IDENT : mlt_pkg::MODE_NUMBER;
        origin_d = pos_q;
        len_d    = mlt_pkg::LenW'(1);
        kp_d     = mlt_pkg::KwNone;
        if (in_byte_q == mlt_pkg::ChrLowP) kp_d = mlt_pkg::KwP;
        if (in_byte_q == mlt_pkg::ChrLowI) kp_d = mlt_pkg::KwI;
      end else begin
        push_b = 1'b1;
      end
    end
    res_a.last = !push_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mlt_pkg::MODE_IDLE;
      kp_q     <= mlt_pkg::KwNone;
      origin_q <= '0;
      len_q    <= '0;
      line_q   <= mlt_pkg::LineW'(1);
      pos_q    <= '0;
    end else if (proc_en) begin
      mode_q   <= mode_d;
      kp_q     <= kp_d;
      origin_q <= origin_d;
      len_q    <= len_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
    end
  end

  assign pop   = m_axis_tvalid_o && m_axis_tready_i;
  assign idx_b = wr_q + mlt_pkg::FifoAw'(push_a);
  assign cnt_d = cnt_q
               + mlt_pkg::CntW'(proc_en && push_a)
               + mlt_pkg::CntW'(proc_en && push_b)
               - mlt_pkg::CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (proc_en) begin
        wr_q <= wr_q + mlt_pkg::FifoAw'(push_a) + mlt_pkg::FifoAw'(push_b);
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && push_a) begin
      fifo_q[wr_q] <= res_a;
    end
    if (proc_en && push_b) begin
      fifo_q[idx_b] <= res_b;
    end
  end

  assign head            = fifo_q[rd_q];
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {4'b0000, head.line, head.length, head.start, head.kind};
  assign m_axis_tlast_o  = head.last;

  `ASSERT_SAME(a_queue_bound, clk_i, rst_ni, 1'b1,
    cnt_q <= mlt_pkg::CntW'(mlt_pkg::FifoDepth))
  `ASSERT_SAME(a_line_nonzero, clk_i, rst_ni, 1'b1, line_q != '0)
  `ASSERT_NEXT(a_end_restart, clk_i, rst_ni,
    proc_en && in_byte_q == mlt_pkg::ChrEnd,
    pos_q == '0 && line_q == mlt_pkg::LineW'(1) && mode_q == mlt_pkg::MODE_IDLE)

endmodule

// ----- verif/tb_mini_language_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// Mini language tokenizer testbench
// Feeds source text one byte per request and predicts the token stream in the
// bench. Every token is checked field by field against the oldest prediction.
// The stimulus covers directed text, a long output stall and random token
// sequences with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mini_language_tokenizer_top;
  import mlt_pkg::*;

  localparam int unsigned StallMax      = 5;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBytes   = 1840;
  localparam int unsigned ReportMax     = 10;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_WORD,
    SCAN_DIGITS
  } scan_state_e;

  typedef struct packed {
    tok_kind_e        kind;
    logic [PosW-1:0]  start;
    logic [LenW-1:0]  length;
    logic [LineW-1:0] line;
    logic             last;
  } token_exp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  mini_language_tokenizer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  token_exp_t       tok_expect[$];
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  int unsigned      bytes_sent;
  int unsigned      rx_hold;
  bit               tx_idle_on;
  bit               rx_idle_on;

  scan_state_e      sc_state;
  logic [3:0]       sc_kw;
  logic [PosW-1:0]  sc_origin;
  logic [LenW-1:0]  sc_len;
  logic [LineW-1:0] sc_line;
  logic [PosW-1:0]  sc_pos;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void scanner_clear();
    sc_state  = SCAN_IDLE;
    sc_kw     = KwNone;
    sc_origin = '0;
    sc_len    = '0;
    sc_line   = LineW'(1);
    sc_pos    = '0;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChrUnderscore;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [3:0] keyword_step(logic [3:0] p, logic [7:0] c);
    case (p)
      KwP:     return (c == ChrLowR) ? KwPr : KwNone;
      KwPr:    return (c == ChrLowI) ? KwPri : KwNone;
      KwPri:   return (c == ChrLowN) ? KwPrin : KwNone;
      KwPrin:  return (c == ChrLowT) ? KwPrint : KwNone;
      KwI:     return (c == ChrLowN) ? KwIn : KwNone;
      KwIn:    return (c == ChrLowT) ? KwInt : KwNone;
      default: return KwNone;
    endcase
  endfunction

  function automatic tok_kind_e operator_kind(logic [7:0] c);
    case (c)
      ChrPlus:   return TK_PLUS;
      ChrMinus:  return TK_MINUS;
      ChrStar:   return TK_STAR;
      ChrSlash:  return TK_SLASH;
      ChrEqual:  return TK_EQUAL;
      ChrSemi:   return TK_SEMI;
      ChrLparen: return TK_LPAREN;
      ChrRparen: return TK_RPAREN;
      default:   return TK_ERROR;
    endcase
  endfunction

  // A byte that closes a word or a number is scanned again on its own.
  function automatic void scan_byte(logic [7:0] c);
    token_exp_t      found[$];
    tok_kind_e       word_kind;
    logic [PosW-1:0] here;
    logic            rescan;
    logic            restart;
    here    = sc_pos;
    rescan  = 1'b1;
    restart = 1'b0;
    if (sc_state == SCAN_WORD) begin
      if (is_alpha(c) || is_digit(c)) begin
        sc_kw = keyword_step(sc_kw, c);
        if (sc_len != LenMax) sc_len++;
        rescan = 1'b0;
      end else begin
        if (sc_kw == KwPrint) word_kind = TK_PRINT;
        else if (sc_kw == KwInt) word_kind = TK_INT;
        else word_kind = TK_IDENT;
        found.push_back(token_exp_t'{word_kind, sc_origin, sc_len, sc_line, 1'b0});
        sc_state = SCAN_IDLE;
      end
    end else if (sc_state == SCAN_DIGITS) begin
      if (is_digit(c)) begin
        if (sc_len != LenMax) sc_len++;
        rescan = 1'b0;
      end else begin
        found.push_back(token_exp_t'{TK_NUMBER, sc_origin, sc_len, sc_line, 1'b0});
        sc_state = SCAN_IDLE;
      end
    end
    if (rescan) begin
      if (c == ChrEnd) begin
        found.push_back(token_exp_t'{TK_END, here, LenW'(0), sc_line, 1'b0});
        restart = 1'b1;
      end else if (c == ChrSpace || c == ChrTab || c == ChrNewline) begin
        if (c == ChrNewline && sc_line != LineMax) sc_line++;
      end else if (is_alpha(c)) begin
        sc_state  = SCAN_WORD;
        sc_origin = here;
        sc_len    = LenW'(1);
        sc_kw     = (c == ChrLowP) ? KwP : (c == ChrLowI) ? KwI : KwNone;
      end else if (is_digit(c)) begin
        sc_state  = SCAN_DIGITS;
        sc_origin = here;
        sc_len    = LenW'(1);
        sc_kw     = KwNone;
      end else begin
        found.push_back(token_exp_t'{operator_kind(c), here, LenW'(1), sc_line, 1'b0});
      end
    end
    if (sc_pos != PosMax) sc_pos++;
    if (found.size() != 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) tok_expect.push_back(found[i]);
    if (restart) scanner_clear();
  endfunction

  task automatic send_byte(input logic [7:0] c);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, StallMax) : 0;
    repeat (gap) @(negedge clk_i) s_axis_tvalid_i = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    scan_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_tokens_done();
    @(negedge clk_i) s_axis_tvalid_i = 1'b0;
    while (tok_expect.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_tokens();
    send_byte(ChrEnd);
    send_text("print(int)+pr-12*_Z9/a;=in");
    send_byte(ChrEnd);
    wait_tokens_done();
  endtask

  task automatic test_whitespace_and_errors();
    send_text(" \t\nx@ 42");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("\n7_ printx int9\n99");
    send_byte(ChrEnd);
    wait_tokens_done();
  endtask

  task automatic test_output_stall();
    bit keep;
    keep       = tx_idle_on;
    tx_idle_on = 1'b0;
    rx_hold    = 150;
    repeat (24) send_text("a+");
    tx_idle_on = keep;
    wait_tokens_done();
  endtask

  task automatic test_random_text();
    string       kw_list[8] = '{"print", "int", "pri", "in", "printf", "int9", "p", "i"};
    logic [7:0]  ops[8] = '{ChrPlus, ChrMinus, ChrStar, ChrSlash,
                            ChrEqual, ChrSemi, ChrLparen, ChrRparen};
    logic [7:0]  blanks[3] = '{ChrSpace, ChrTab, ChrNewline};
    int unsigned first;
    int unsigned next_switch;
    int unsigned r;
    int unsigned len;
    bit          paused;
    first       = bytes_sent;
    next_switch = bytes_sent;
    paused      = 1'b0;
    while (bytes_sent - first < RandomBytes) begin
      if (bytes_sent >= next_switch) begin
        tx_idle_on  = ($urandom_range(0, 3) != 0);
        rx_idle_on  = ($urandom_range(0, 3) != 0);
        next_switch = bytes_sent + 250;
      end
      if (!paused && bytes_sent - first >= RandomBytes / 2) begin
        wait_tokens_done();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        len = $urandom_range(1, 8);
        r   = $urandom_range(0, 52);
        send_byte(8'(r < 26 ? 8'("a") + r : r < 52 ? 8'("A") + r - 26 : ChrUnderscore));
        repeat (len - 1) begin
          r = $urandom_range(0, 62);
          if (r < 26) send_byte(8'(8'("a") + r));
          else if (r < 52) send_byte(8'(8'("A") + r - 26));
          else if (r < 62) send_byte(8'(8'("0") + r - 52));
          else send_byte(ChrUnderscore);
        end
      end else if (r < 40) begin
        send_text(kw_list[$urandom_range(0, 7)]);
      end else if (r < 55) begin
        repeat ($urandom_range(1, 6)) send_byte(8'(8'("0") + $urandom_range(0, 9)));
      end else if (r < 70) begin
        send_byte(ops[$urandom_range(0, 7)]);
      end else if (r < 85) begin
        send_byte(blanks[$urandom_range(0, 2)]);
      end else if (r < 92) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_byte(8'($urandom_range(128, 255)));
      end else begin
        send_byte(ChrEnd);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_tokens_done();
  endtask

  initial begin
    int unsigned stall;
    int unsigned hold;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold != 0) begin
        hold    = rx_hold;
        rx_hold = 0;
        repeat (hold) @(negedge clk_i) m_axis_tready_i = 1'b0;
      end
      stall = rx_idle_on ? $urandom_range(0, StallMax) : 0;
      repeat (stall) @(negedge clk_i) m_axis_tready_i = 1'b0;
      @(negedge clk_i) m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  task automatic note_mismatch(input token_exp_t want, input bit none_waiting);
    mismatches++;
    if (mismatches <= ReportMax) begin
      if (none_waiting)
        $display("unexpected token: kind %0d start %0d length %0d line %0d last %0b",
                 m_axis_tdata_o[3:0], m_axis_tdata_o[27:4], m_axis_tdata_o[43:28],
                 m_axis_tdata_o[59:44], m_axis_tlast_o);
      else
        $display("token mismatch: expected kind %0d start %0d length %0d line %0d last %0b,",
                 want.kind, want.start, want.length, want.line, want.last,
                 " got kind %0d start %0d length %0d line %0d last %0b pad %0h",
                 m_axis_tdata_o[3:0], m_axis_tdata_o[27:4], m_axis_tdata_o[43:28],
                 m_axis_tdata_o[59:44], m_axis_tlast_o, m_axis_tdata_o[63:60]);
    end
  endtask

  always @(posedge clk_i) begin
    token_exp_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (tok_expect.size() == 0) begin
        want = '0;
        note_mismatch(want, 1'b1);
      end else begin
        want = tok_expect.pop_front();
        if (m_axis_tdata_o[3:0] !== want.kind || m_axis_tdata_o[27:4] !== want.start ||
            m_axis_tdata_o[43:28] !== want.length || m_axis_tdata_o[59:44] !== want.line ||
            m_axis_tdata_o[63:60] !== 4'h0 || m_axis_tlast_o !== want.last) begin
          note_mismatch(want, 1'b0);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("mini_language_tokenizer_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    mismatches      = 0;
    quiet_cycles    = 0;
    bytes_sent      = 0;
    rx_hold         = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    scanner_clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    test_directed_tokens();
    test_whitespace_and_errors();
    test_output_stall();
    test_random_text();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && tok_expect.size() == 0) begin
      $display("mini_language_tokenizer_top verification clean");
    end else begin
      $display("mini_language_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule
